FILE: sv/bam_pkg.sv
// bam_pkg: shared types, codes and constants of the allocation bitmap
// used by bam_zcnt, bam_ctrl, bitmap_allocation_map_top and bam_checker
`default_nettype none

package bam_pkg;

    localparam int MAP_WORDS_DEF = 64;
    localparam int WORD_BITS_DEF = 64;

    localparam int OP_W         = 2;
    localparam int INDEX_W      = 14;
    localparam int FREE_COUNT_W = 13;
    localparam int WIU_W        = 7;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [WIU_W-1:0]      WIU_RESET          = 7'd64;
    localparam logic [CFG_ADDR_W-1:0] REG_WORDS_IN_USE   = 2'd0;

    localparam logic STATUS_OK           = 1'b0;
    localparam logic STATUS_OUT_OF_RANGE = 1'b1;

    // free bits in each nibble value
    localparam logic [2:0] ZEROS_IN_NIBBLE [16] = '{
        3'd4, 3'd3, 3'd3, 3'd2, 3'd3, 3'd2, 3'd2, 3'd1,
        3'd3, 3'd2, 3'd2, 3'd1, 3'd2, 3'd1, 3'd1, 3'd0
    };

    typedef enum logic [OP_W-1:0] {
        OP_TEST  = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_COUNT = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_BIT_RD,
        ST_BIT_WR,
        ST_CNT
    } state_t;

    typedef struct packed {
        logic                    status;
        logic                    bit_value;
        logic                    changed;
        logic [FREE_COUNT_W-1:0] free_count;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/bam_ram.sv
// bam_ram: generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none

module bam_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic             re,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/bam_zcnt.sv
// bam_zcnt: counts the zero bits of one bitmap word with a nibble table
// depends on bam_pkg
`default_nettype none

module bam_zcnt #(
    parameter int WORD_BITS = bam_pkg::WORD_BITS_DEF,
    parameter int ZW        = $clog2(WORD_BITS + 1)
) (
    input  wire logic [WORD_BITS-1:0] word,
    output logic      [ZW-1:0]        zeros
);

    localparam int NIB   = (WORD_BITS + 3) / 4;
    localparam int QUADS = (NIB + 3) / 4;
    localparam int PW    = QUADS * 16;

    logic [PW-1:0] padded;
    logic [4:0]    quad_sum [QUADS];
    logic [ZW-1:0] total;

    // pad with ones so the filler counts as taken
    always_comb
    begin
        padded = '1;
        padded[WORD_BITS-1:0] = word;
        for (int q = 0; q < QUADS; q++)
        begin
            quad_sum[q] = '0;
            for (int k = 0; k < 4; k++)
            begin
                quad_sum[q] = quad_sum[q]
                    + 5'(bam_pkg::ZEROS_IN_NIBBLE[padded[16*q + 4*k +: 4]]);
            end
        end
        total = '0;
        for (int q = 0; q < QUADS; q++)
        begin
            total = total + ZW'(quad_sum[q]);
        end
    end

    assign zeros = total;

endmodule

`default_nettype wire

FILE: sv/bam_ctrl.sv
// bam_ctrl: request sequencer, read-modify-write of bitmap words and free-bit scan
// depends on bam_pkg and bam_zcnt; drives the bitmap ram
`default_nettype none

module bam_ctrl #(
    parameter int MAP_WORDS = bam_pkg::MAP_WORDS_DEF,
    parameter int WORD_BITS = bam_pkg::WORD_BITS_DEF,
    parameter int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire logic [bam_pkg::OP_W-1:0]           operation,
    input  wire logic [bam_pkg::INDEX_W-1:0]        bit_index,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_stall,
    output bam_pkg::res_t                           rsp,
    input  wire logic [bam_pkg::WIU_W-1:0]          words_in_use,
    output logic                                    ram_we,
    output logic                                    ram_re,
    output logic [AW-1:0]                           ram_addr,
    output logic [WORD_BITS-1:0]                    ram_wdata,
    input  wire logic [WORD_BITS-1:0]               ram_rdata
);

    localparam int RAW_W = bam_pkg::INDEX_W - 1;
    localparam int NW    = $clog2(MAP_WORDS + 1);
    localparam int CW    = (NW > bam_pkg::WIU_W) ? NW : bam_pkg::WIU_W;
    localparam int KSH   = 20;
    localparam int RECIP = ((1 << KSH) + WORD_BITS - 1) / WORD_BITS;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int PRW   = RAW_W + RW;
    localparam int QW    = PRW - KSH;
    localparam int CMPW  = (QW > CW) ? QW : CW;
    localparam int BW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int ZW    = $clog2(WORD_BITS + 1);
    localparam int FCW   = bam_pkg::FREE_COUNT_W;

    localparam logic [RW-1:0]    RECIP_C = RW'(RECIP);
    localparam logic [RAW_W-1:0] WB_C    = RAW_W'(WORD_BITS);
    localparam logic [AW-1:0]    LAST_C  = AW'(MAP_WORDS - 1);
    localparam logic [NW-1:0]    MAPW_C  = NW'(MAP_WORDS);
    localparam logic [FCW-1:0]   FC_ZERO = '0;

    bam_pkg::state_t state_reg, state_next;

    bam_pkg::op_t      op_reg;
    logic [RAW_W-1:0]  raw_reg;
    logic              neg_reg;
    logic [QW-1:0]     q_reg;
    logic              range_reg;
    logic [BW-1:0]     bitpos_reg;
    logic [AW-1:0]     clr_reg;
    logic [NW-1:0]     idx_reg;
    logic              pend_reg;
    logic [FCW-1:0]    acc_reg;
    logic              rsp_valid_reg;
    bam_pkg::res_t     rsp_reg, rsp_next;

    logic [PRW-1:0]    prod;
    logic [QW-1:0]     q_calc;
    logic [NW-1:0]     n_act;
    logic              in_range;
    logic [RAW_W-1:0]  rem;
    logic              accept;
    logic              fin;
    logic              out_free;
    logic              idx_lt;
    logic              cnt_done;
    logic              old_bit;
    logic              chg;
    logic [WORD_BITS-1:0] mask;
    logic [ZW-1:0]     zeros;

    bam_zcnt #(
        .WORD_BITS (WORD_BITS),
        .ZW        (ZW)
    ) u_zcnt (
        .word  (ram_rdata),
        .zeros (zeros)
    );

    // word number by reciprocal multiply, exact for all 13-bit indexes
    assign prod   = PRW'(bit_index[RAW_W-1:0]) * PRW'(RECIP_C);
    assign q_calc = prod[PRW-1:KSH];

    assign n_act = (CW'(words_in_use) > CW'(MAPW_C)) ? MAPW_C : NW'(words_in_use);

    assign in_range = !neg_reg && (CMPW'(q_reg) < CMPW'(n_act));
    assign rem      = raw_reg - RAW_W'(RAW_W'(q_reg) * WB_C);

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign idx_lt   = idx_reg < n_act;
    assign cnt_done = !idx_lt && !pend_reg;

    assign old_bit = ram_rdata[bitpos_reg];
    assign mask    = WORD_BITS'(1) << bitpos_reg;
    assign chg     = range_reg && (((op_reg == bam_pkg::OP_SET) && !old_bit)
                                || ((op_reg == bam_pkg::OP_CLEAR) && old_bit));

    assign accept = req_valid && !req_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bam_pkg::ST_CLR:
            begin
                if (clr_reg == LAST_C)
                begin
                    state_next = bam_pkg::ST_IDLE;
                end
            end
            bam_pkg::ST_BIT_RD:
            begin
                state_next = bam_pkg::ST_BIT_WR;
            end
            bam_pkg::ST_IDLE, bam_pkg::ST_BIT_WR, bam_pkg::ST_CNT:
            begin
                if (accept)
                begin
                    if (bam_pkg::op_t'(operation) == bam_pkg::OP_COUNT)
                    begin
                        state_next = bam_pkg::ST_CNT;
                    end
                    else
                    begin
                        state_next = bam_pkg::ST_BIT_RD;
                    end
                end
                else if (fin)
                begin
                    state_next = bam_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bam_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = '0;
        ram_wdata = '0;
        fin       = 1'b0;
        rsp_next  = '{status: bam_pkg::STATUS_OK, bit_value: 1'b0, changed: 1'b0,
                      free_count: FC_ZERO};
        case (state_reg)
            bam_pkg::ST_CLR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
            end
            bam_pkg::ST_BIT_RD:
            begin
                ram_re   = in_range;
                ram_addr = q_reg[AW-1:0];
            end
            bam_pkg::ST_BIT_WR:
            begin
                fin      = out_free;
                ram_we   = out_free && chg;
                ram_addr = q_reg[AW-1:0];
                if (op_reg == bam_pkg::OP_SET)
                begin
                    ram_wdata = ram_rdata | mask;
                end
                else
                begin
                    ram_wdata = ram_rdata & ~mask;
                end
                rsp_next.status    = range_reg ? bam_pkg::STATUS_OK
                                               : bam_pkg::STATUS_OUT_OF_RANGE;
                rsp_next.bit_value = range_reg && old_bit;
                rsp_next.changed   = chg;
            end
            bam_pkg::ST_CNT:
            begin
                ram_re   = idx_lt;
                ram_addr = idx_reg[AW-1:0];
                fin      = cnt_done && out_free;
                rsp_next.free_count = acc_reg;
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
    end

    assign req_stall = !((state_reg == bam_pkg::ST_IDLE) || fin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bam_pkg::ST_CLR;
            clr_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == bam_pkg::ST_CLR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (accept)
            begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (state_reg == bam_pkg::ST_CNT)
            begin
                idx_reg  <= idx_reg + NW'(idx_lt);
                pend_reg <= idx_lt;
            end
            if (fin)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= bam_pkg::op_t'(operation);
            raw_reg <= bit_index[RAW_W-1:0];
            neg_reg <= bit_index[RAW_W];
            q_reg   <= q_calc;
            acc_reg <= '0;
        end
        else if ((state_reg == bam_pkg::ST_CNT) && pend_reg)
        begin
            acc_reg <= acc_reg + FCW'(zeros);
        end
        if (state_reg == bam_pkg::ST_BIT_RD)
        begin
            range_reg  <= in_range;
            bitpos_reg <= rem[BW-1:0];
        end
        if (fin)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

FILE: sv/bitmap_allocation_map_top.sv
// bitmap_allocation_map_top: allocation bitmap with test, set, clear and free count
// depends on bam_pkg, bam_ram, bam_ctrl; the config register sits here
//
// Requests come in on req_valid/req_stall with operation and bit_index; each
// item gives one result on rsp_valid/rsp_stall with status, bit_value,
// changed and free_count. Items are taken at a rising edge with valid high
// and stall low. words_in_use is written through the APB port at address 0.
// Test, set and clear read the word in ST_BIT_RD, then in ST_BIT_WR the
// modified word is written back, if the bit flips, while the result is
// loaded. The next item can be taken in the write-back cycle if the output is free.
// Count walks the words in use, capped at MAP_WORDS, through the single ram
// port, one word a cycle; with no word in use it reads nothing.
// A result appears in the output register the edge after the last cycle.
// After reset a clearing pass writes zero to all MAP_WORDS words, one a
// cycle; req_stall stays high until it ends, config writes are taken.
// While rsp_stall holds the result, one more item can be worked on; it
// then waits in its final cycle with req_stall high.
`default_nettype none

module bitmap_allocation_map_top #(
    parameter int MAP_WORDS = bam_pkg::MAP_WORDS_DEF,
    parameter int WORD_BITS = bam_pkg::WORD_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 req_valid,
    output logic                                      req_stall,
    input  wire logic [bam_pkg::OP_W-1:0]             operation,
    input  wire logic signed [bam_pkg::INDEX_W-1:0]   bit_index,
    output logic                                      rsp_valid,
    input  wire logic                                 rsp_stall,
    output logic                                      status,
    output logic                                      bit_value,
    output logic                                      changed,
    output logic [bam_pkg::FREE_COUNT_W-1:0]          free_count,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [bam_pkg::CFG_ADDR_W-1:0]       paddr,
    input  wire logic [bam_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [bam_pkg::CFG_DATA_W-1:0]            prdata,
    output logic                                      pready
);

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [bam_pkg::WIU_W-1:0] wiu_reg;
    logic                      ram_we;
    logic                      ram_re;
    logic [AW-1:0]             ram_addr;
    logic [WORD_BITS-1:0]      ram_wdata;
    logic [WORD_BITS-1:0]      ram_rdata;
    bam_pkg::res_t             rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wiu_reg <= bam_pkg::WIU_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr == bam_pkg::REG_WORDS_IN_USE))
        begin
            wiu_reg <= pwdata[bam_pkg::WIU_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == bam_pkg::REG_WORDS_IN_USE)
                  ? bam_pkg::CFG_DATA_W'(wiu_reg) : '0;

    bam_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    bam_ctrl #(
        .MAP_WORDS (MAP_WORDS),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .operation    (operation),
        .bit_index    (bit_index),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .words_in_use (wiu_reg),
        .ram_we       (ram_we),
        .ram_re       (ram_re),
        .ram_addr     (ram_addr),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata)
    );

    assign status     = rsp.status;
    assign bit_value  = rsp.bit_value;
    assign changed    = rsp.changed;
    assign free_count = rsp.free_count;

endmodule

`default_nettype wire

FILE: sv/bam_checker.sv
// bam_checker: port-level assertions for the allocation bitmap, bound to the top level
// depends on bam_pkg
`default_nettype none

module bam_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 req_valid,
    input wire logic                                 req_stall,
    input wire logic [bam_pkg::OP_W-1:0]             operation,
    input wire logic signed [bam_pkg::INDEX_W-1:0]   bit_index,
    input wire logic                                 rsp_valid,
    input wire logic                                 rsp_stall,
    input wire logic                                 status,
    input wire logic                                 bit_value,
    input wire logic                                 changed,
    input wire logic [bam_pkg::FREE_COUNT_W-1:0]     free_count,
    input wire logic                                 psel,
    input wire logic                                 penable,
    input wire logic                                 pwrite,
    input wire logic [bam_pkg::CFG_ADDR_W-1:0]       paddr,
    input wire logic [bam_pkg::CFG_DATA_W-1:0]       pwdata,
    input wire logic [bam_pkg::CFG_DATA_W-1:0]       prdata,
    input wire logic                                 pready
);

    // a held result keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(bit_value)
            && $stable(changed) && $stable(free_count))
        else $error("held result changed");

    // out of range results carry nothing else
    a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == bam_pkg::STATUS_OUT_OF_RANGE)
            |-> !bit_value && !changed && (free_count == '0))
        else $error("out of range result with data");

    // a flip comes only with an ok status and never with a count
    a_changed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && changed |-> (status == bam_pkg::STATUS_OK) && (free_count == '0))
        else $error("changed on bad result");

    // a count result has no bit fields
    a_count_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (free_count != '0) |-> (status == bam_pkg::STATUS_OK)
            && !bit_value && !changed)
        else $error("count result with bit fields");

endmodule

bind bitmap_allocation_map_top bam_checker u_bam_checker (.*);

`default_nettype wire

FILE: sim/bam_checker.sv
// bam_scoreboard: watches the request, result and apb ports of the allocation bitmap,
// keeps its own copy of the bitmap and compares every result field by field
// depends on bam_pkg
module bam_scoreboard #(
    parameter int MAP_WORDS = bam_pkg::MAP_WORDS_DEF,
    parameter int WORD_BITS = bam_pkg::WORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    input  logic                             req_stall,
    input  logic [bam_pkg::OP_W-1:0]         operation,
    input  logic [bam_pkg::INDEX_W-1:0]      bit_index,
    input  logic                             rsp_valid,
    input  logic                             rsp_stall,
    input  logic                             status,
    input  logic                             bit_value,
    input  logic                             changed,
    input  logic [bam_pkg::FREE_COUNT_W-1:0] free_count,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [bam_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [bam_pkg::CFG_DATA_W-1:0]   pwdata,
    output int                               outstanding,
    output int                               mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FCW     = bam_pkg::FREE_COUNT_W;
    localparam int INDEX_W = bam_pkg::INDEX_W;
    localparam int WIU_W   = bam_pkg::WIU_W;

    logic [WORD_BITS-1:0] map_words [MAP_WORDS];
    logic [WIU_W-1:0]     words_in_use;
    bam_pkg::res_t        awaited_results [$];

    function automatic bam_pkg::res_t serve_request(bam_pkg::op_t op,
                                                    logic [INDEX_W-1:0] idx);
        bam_pkg::res_t r;
        int   n_words;
        int   free_bits;
        int   word_sel;
        int   bit_sel;
        int   w;
        r = '0;
        n_words = (int'(words_in_use) > MAP_WORDS) ? MAP_WORDS : int'(words_in_use);
        if (op == bam_pkg::OP_COUNT)
        begin
            free_bits = 0;
            for (w = 0; w < n_words; w++)
                free_bits += WORD_BITS - $countones(map_words[w]);
            r.free_count = FCW'(free_bits);
        end
        else if (idx[INDEX_W-1] || int'(idx) >= n_words * WORD_BITS)
            r.status = bam_pkg::STATUS_OUT_OF_RANGE;
        else
        begin
            word_sel = int'(idx) / WORD_BITS;
            bit_sel = int'(idx) % WORD_BITS;
            r.status = bam_pkg::STATUS_OK;
            r.bit_value = map_words[word_sel][bit_sel];
            if (op == bam_pkg::OP_SET && !r.bit_value)
            begin
                map_words[word_sel][bit_sel] = 1'b1;
                r.changed = 1'b1;
            end
            else if (op == bam_pkg::OP_CLEAR && r.bit_value)
            begin
                map_words[word_sel][bit_sel] = 1'b0;
                r.changed = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic int field_differs(string name, logic [FCW-1:0] want,
                                         logic [FCW-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bam_pkg::res_t want;
        int   bad;
        if (!rst_n)
        begin
            foreach (map_words[i])
                map_words[i] = '0;
            words_in_use = bam_pkg::WIU_RESET;
            awaited_results.delete();
            outstanding <= 0;
            mismatches <= 0;
        end
        else
        begin
            bad = 0;
            if (psel && penable && pwrite && pready && paddr == bam_pkg::REG_WORDS_IN_USE)
                words_in_use = pwdata[WIU_W-1:0];
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result item with nothing awaited");
                    bad++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    bad += field_differs("status", FCW'(want.status), FCW'(status));
                    bad += field_differs("bit_value", FCW'(want.bit_value),
                                         FCW'(bit_value));
                    bad += field_differs("changed", FCW'(want.changed), FCW'(changed));
                    bad += field_differs("free_count", want.free_count, free_count);
                end
            end
            if (req_valid && !req_stall)
                awaited_results.push_back(serve_request(bam_pkg::op_t'(operation),
                                                        bit_index));
            outstanding <= awaited_results.size();
            mismatches <= mismatches + bad;
        end
    end

endmodule

FILE: sim/testbench.sv
// testbench: drives requests, result stalls and words_in_use writes into the
// allocation bitmap and gives the verdict; depends on bam_pkg, bam_scoreboard
// and bitmap_allocation_map_top
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT    = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 70;
    localparam int PHASE_ITEMS    = 150;
    localparam int PRESSURE_ITEMS = 40;
    localparam int PHASES         = 10;
    localparam int INDEX_W        = bam_pkg::INDEX_W;
    localparam int CFG_DATA_W     = bam_pkg::CFG_DATA_W;

    logic                                    clk = 1'b0;
    logic                                    rst_n = 1'b0;
    logic                                    req_valid = 1'b0;
    logic                                    req_stall;
    logic [bam_pkg::OP_W-1:0]                operation = '0;
    logic signed [INDEX_W-1:0]               bit_index = '0;
    logic                                    rsp_valid;
    logic                                    rsp_stall = 1'b0;
    logic                                    status;
    logic                                    bit_value;
    logic                                    changed;
    logic [bam_pkg::FREE_COUNT_W-1:0]        free_count;
    logic                                    psel = 1'b0;
    logic                                    penable = 1'b0;
    logic                                    pwrite = 1'b0;
    logic [bam_pkg::CFG_ADDR_W-1:0]          paddr = '0;
    logic [CFG_DATA_W-1:0]                   pwdata = '0;
    logic [CFG_DATA_W-1:0]                   prdata;
    logic                                    pready;

    int outstanding;
    int mismatches;
    int stall_pct = 0;
    int send_idle_pct = 0;
    int hold_asks = 0;
    int hold_grants = 0;
    int quiet_cycles = 0;
    int cur_words = bam_pkg::WIU_RESET;
    int words_plan [8] = '{2, 64, 1, 5, 0, 127, 16, 3};

    bitmap_allocation_map_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .operation  (operation),
        .bit_index  (bit_index),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .bit_value  (bit_value),
        .changed    (changed),
        .free_count (free_count),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    bam_scoreboard u_scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .operation   (operation),
        .bit_index   (bit_index),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .bit_value   (bit_value),
        .changed     (changed),
        .free_count  (free_count),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_item(bam_pkg::op_t op, logic [INDEX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        bit_index <= idx;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic send_random();
        bam_pkg::op_t op;
        int unsigned  limit;
        logic [INDEX_W-1:0] idx;
        limit = ((cur_words > bam_pkg::MAP_WORDS_DEF) ? bam_pkg::MAP_WORDS_DEF : cur_words)
              * bam_pkg::WORD_BITS_DEF;
        if ($urandom_range(99) < 6)
            op = bam_pkg::OP_COUNT;
        else
            op = bam_pkg::op_t'($urandom_range(2));
        if (limit > 0 && $urandom_range(99) < 85)
            idx = INDEX_W'($urandom_range(limit - 1));
        else
            idx = INDEX_W'($urandom);
        send_item(op, idx);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic program_words(int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= bam_pkg::REG_WORDS_IN_USE;
        pwdata <= CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_words = value;
    endtask

    // result side: random stalls plus a long hold-off when one is asked for
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_grants)
            begin
                hold_grants = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int ph;
        int mode;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        program_words(64);

        send_item(bam_pkg::OP_COUNT, '0);
        send_item(bam_pkg::OP_TEST, 14'd0);
        send_item(bam_pkg::OP_SET, 14'd0);
        send_item(bam_pkg::OP_SET, 14'd0);
        send_item(bam_pkg::OP_TEST, 14'd0);
        send_item(bam_pkg::OP_CLEAR, 14'd0);
        send_item(bam_pkg::OP_CLEAR, 14'd0);
        send_item(bam_pkg::OP_SET, 14'd63);
        send_item(bam_pkg::OP_SET, 14'd64);
        send_item(bam_pkg::OP_SET, 14'd4095);
        send_item(bam_pkg::OP_TEST, 14'd4095);
        send_item(bam_pkg::OP_TEST, 14'd4096);
        send_item(bam_pkg::OP_SET, 14'd8191);
        send_item(bam_pkg::OP_CLEAR, 14'h3fff);
        send_item(bam_pkg::OP_TEST, 14'h2000);
        send_item(bam_pkg::OP_COUNT, 14'h3fff);
        drain_results();
        program_words(1);
        send_item(bam_pkg::OP_SET, 14'd64);
        send_item(bam_pkg::OP_CLEAR, 14'd63);
        send_item(bam_pkg::OP_COUNT, '0);
        drain_results();
        program_words(0);
        send_item(bam_pkg::OP_TEST, 14'd0);
        send_item(bam_pkg::OP_COUNT, '0);
        drain_results();
        program_words(127);
        send_item(bam_pkg::OP_CLEAR, 14'd4095);
        send_item(bam_pkg::OP_SET, 14'd4096);
        send_item(bam_pkg::OP_COUNT, '0);
        drain_results();

        // long result hold-off with the request side pushing
        program_words(4);
        hold_asks <= hold_asks + 1;
        repeat (PRESSURE_ITEMS) send_random();

        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            program_words((ph < 8) ? words_plan[ph] : $urandom_range(127));
            mode = ph % 4;
            send_idle_pct = (mode == 1) ? 74 : (mode == 3) ? 38 : 0;
            stall_pct <= (mode == 2) ? 74 : (mode == 3) ? 38 : 0;
            repeat (PHASE_ITEMS) send_random();
        end

        drain_results();
        stall_pct <= 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
